// ===== src/assert_macros.svh =====
// Assertion macros shared by the retransmit queue RTL.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define RQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RQ_ASSERT(lbl, clk, rst_n, prop)
`define RQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/rq_pkg.sv =====
// Types, codes and defaults for the retransmit queue.
// No dependencies; used by every RTL file of the block.
package rq_pkg;
	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned SLOT_COUNT_DEF = 8;
	localparam logic [31:0] RETRY_RESET = 32'd1000;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_ENQ = 2'd1;
	localparam logic [1:0] ACT_ACK = 2'd2;
	localparam logic [1:0] ACT_SEND = 2'd3;

	localparam logic [2:0] KIND_GRANT = 3'd0;
	localparam logic [2:0] KIND_ENQ = 3'd1;
	localparam logic [2:0] KIND_ACK = 3'd2;
	localparam logic [2:0] KIND_TX = 3'd3;
	localparam logic [2:0] KIND_UNREACH = 3'd4;
	localparam logic [2:0] KIND_DONE = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_STATE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [1:0] CONN_JOINING = 2'd1;
	localparam logic [1:0] CONN_CONNECTED = 2'd2;

	localparam logic CFG_CONN = 1'b0;
	localparam logic CFG_RETRY = 1'b1;

	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] rcpt;
		logic [2:0]  slot;
		logic [9:0]  len;
		logic [3:0]  maxa;
		logic [3:0]  done;
		logic [31:0] tm;
	} entry_t;

	typedef struct packed {
		logic remove;
		logic append;
		logic update;
	} tbl_ctl_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  status;
		logic [31:0] seq;
		logic [15:0] rcpt;
		logic [2:0]  slot;
		logic [9:0]  len;
		logic [3:0]  attempt;
		logic [4:0]  sent;
		logic        last;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE, S_ALLOC, S_GRANT, S_EVICT, S_ENQ, S_ACK, S_SEND, S_PURGE
	} seq_state_t;
endpackage

// ===== src/rq_table.sv =====
// Ordered entry table: one read port, in-place update, append and shift-down removal.
// Depends on rq_pkg.
module rq_table #(
	parameter int unsigned QUEUE_DEPTH = rq_pkg::QUEUE_DEPTH_DEF,
	localparam int unsigned IW = $clog2(QUEUE_DEPTH),
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rq_pkg::tbl_ctl_t ctl,
	input  logic [IW-1:0]    idx,
	input  rq_pkg::entry_t   wdata,
	input  logic [IW-1:0]    rd_idx,
	output rq_pkg::entry_t   rdata,
	output logic [CW-1:0]    cnt
);
	rq_pkg::entry_t ent_q [QUEUE_DEPTH];
	logic [CW-1:0] cnt_q;

	assign rdata = ent_q[rd_idx];
	assign cnt = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.remove) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (ctl.append) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.remove) begin
			for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
				if (IW'(j) >= idx) begin
					ent_q[j] <= ent_q[j + 1];
				end
			end
		end else if (ctl.append) begin
			ent_q[cnt_q[IW-1:0]] <= wdata;
		end else if (ctl.update) begin
			ent_q[idx] <= wdata;
		end
	end
endmodule

// ===== src/rq_seq.sv =====
// Sequencer that walks the entry table one entry per cycle while no result waits,
// and forms result words. Depends on rq_pkg; drives rq_table via a control struct.
module rq_seq #(
	parameter int unsigned QUEUE_DEPTH = rq_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned SLOT_COUNT = rq_pkg::SLOT_COUNT_DEF,
	localparam int unsigned IW = $clog2(QUEUE_DEPTH),
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             busy,
	input  logic [1:0]       action,
	input  logic [15:0]      recipient_id,
	input  logic [2:0]       buffer_slot,
	input  logic [9:0]       msg_length,
	input  logic [3:0]       attempt_limit,
	input  logic [31:0]      ack_sequence,
	input  logic [31:0]      now,
	input  logic [1:0]       conn,
	input  logic [31:0]      retry,
	output rq_pkg::tbl_ctl_t ctl,
	output logic [IW-1:0]    idx,
	output rq_pkg::entry_t   wdata,
	output logic [IW-1:0]    rd_idx,
	input  rq_pkg::entry_t   rdata,
	input  logic [CW-1:0]    cnt,
	output logic             out_valid,
	input  logic             out_stall,
	output rq_pkg::result_t  res
);
	rq_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0] idx_q, idx_d, best_q, best_d;
	logic [3:0] best_done_q, best_done_d;
	logic [7:0] used_q, used_d;
	logic first_q, first_d;
	logic [2:0] bslot_q, bslot_d;
	logic [4:0] sent_q, sent_d;
	logic [15:0] rr_q, rr_d;
	logic [31:0] ctr_q, ctr_d;
	logic [15:0] rcpt_q;
	logic [2:0] slot_q;
	logic [9:0] len_q;
	logic [3:0] maxa_q;
	logic [31:0] ack_q, now_q;
	logic ov_q;
	rq_pkg::result_t res_q, res_d;
	logic emit, out_free, at_end, nxt_in, has_free, active;
	logic [2:0] free_slot;
	logic [CW-1:0] idx_p1;

	assign out_free = !ov_q || !out_stall;
	assign out_valid = ov_q;
	assign res = res_q;
	assign busy = (state_q != rq_pkg::S_IDLE);
	assign at_end = (idx_q >= cnt);
	assign idx_p1 = idx_q + 1'b1;
	assign nxt_in = (idx_p1 < cnt);
	assign active = (conn == rq_pkg::CONN_JOINING) || (conn == rq_pkg::CONN_CONNECTED);

	always_comb begin
		has_free = 1'b0;
		free_slot = '0;
		for (int s = 7; s >= 0; s--) begin
			if (s < SLOT_COUNT && !used_q[s]) begin
				has_free = 1'b1;
				free_slot = 3'(s);
			end
		end
		if (SLOT_COUNT > 8) begin
			has_free = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		best_d = best_q;
		best_done_d = best_done_q;
		used_d = used_q;
		first_d = first_q;
		bslot_d = bslot_q;
		sent_d = sent_q;
		rr_d = rr_q;
		ctr_d = ctr_q;
		ctl = '0;
		idx = idx_q[IW-1:0];
		rd_idx = idx_q[IW-1:0];
		wdata = rdata;
		emit = 1'b0;
		res_d = '0;
		res_d.last = 1'b1;
		case (state_q)
			rq_pkg::S_IDLE: begin
				idx_d = '0;
				best_d = '0;
				used_d = '0;
				sent_d = '0;
				first_d = 1'b1;
				if (in_valid) begin
					case (action)
						rq_pkg::ACT_ALLOC: state_d = rq_pkg::S_ALLOC;
						rq_pkg::ACT_ENQ:   state_d = rq_pkg::S_ENQ;
						rq_pkg::ACT_ACK:   state_d = rq_pkg::S_ACK;
						default:           state_d = rq_pkg::S_SEND;
					endcase
				end
			end
			rq_pkg::S_ALLOC: begin
				if (at_end) begin
					state_d = rq_pkg::S_GRANT;
				end else begin
					if (32'(rdata.slot) < SLOT_COUNT) begin
						used_d[rdata.slot] = 1'b1;
					end
					if (idx_q == '0 || rdata.done > best_done_q) begin
						best_d = idx_q;
						best_done_d = rdata.done;
					end
					idx_d = idx_p1;
				end
			end
			rq_pkg::S_GRANT: begin
				if (has_free) begin
					emit = 1'b1;
					res_d.kind = rq_pkg::KIND_GRANT;
					res_d.slot = free_slot;
					if (out_free) begin
						state_d = rq_pkg::S_IDLE;
					end
				end else begin
					idx_d = best_q;
					state_d = rq_pkg::S_EVICT;
				end
			end
			rq_pkg::S_EVICT: begin
				if (!at_end && (first_q || rdata.slot == bslot_q)) begin
					ctl.remove = 1'b1;
					first_d = 1'b0;
					if (first_q) begin
						bslot_d = rdata.slot;
					end
				end else begin
					emit = 1'b1;
					res_d.kind = rq_pkg::KIND_GRANT;
					res_d.slot = bslot_q;
					if (out_free) begin
						state_d = rq_pkg::S_IDLE;
					end
				end
			end
			rq_pkg::S_ENQ: begin
				emit = 1'b1;
				res_d.kind = rq_pkg::KIND_ENQ;
				if (cnt >= CW'(QUEUE_DEPTH)) begin
					res_d.status = rq_pkg::ST_FULL;
				end else begin
					res_d.seq = ctr_q + 1'b1;
				end
				wdata = '{seq: ctr_q + 1'b1, rcpt: rcpt_q, slot: slot_q, len: len_q,
					maxa: maxa_q, done: 4'd0, tm: 32'd0};
				if (out_free) begin
					state_d = rq_pkg::S_IDLE;
					if (cnt < CW'(QUEUE_DEPTH)) begin
						ctl.append = 1'b1;
						ctr_d = ctr_q + 1'b1;
					end
				end
			end
			rq_pkg::S_ACK: begin
				res_d.kind = rq_pkg::KIND_ACK;
				res_d.seq = ack_q;
				if (conn != rq_pkg::CONN_CONNECTED) begin
					emit = 1'b1;
					res_d.status = rq_pkg::ST_BAD_STATE;
				end else if (at_end) begin
					emit = 1'b1;
					res_d.status = rq_pkg::ST_NOT_FOUND;
				end else if (rdata.seq == ack_q) begin
					emit = 1'b1;
					ctl.remove = out_free;
				end else begin
					idx_d = idx_p1;
				end
				if (emit && out_free) begin
					state_d = rq_pkg::S_IDLE;
				end
			end
			rq_pkg::S_SEND: begin
				if (!active || at_end) begin
					emit = 1'b1;
					res_d.kind = rq_pkg::KIND_DONE;
					if (!active) begin
						res_d.status = rq_pkg::ST_BAD_STATE;
					end else begin
						res_d.sent = sent_q;
					end
					if (out_free) begin
						state_d = rq_pkg::S_IDLE;
					end
				end else if (rdata.done >= rdata.maxa) begin
					if (rdata.maxa > 4'd1) begin
						emit = 1'b1;
						res_d.kind = rq_pkg::KIND_UNREACH;
						res_d.rcpt = rdata.rcpt;
						res_d.last = 1'b0;
						if (out_free) begin
							rr_d = rdata.rcpt;
							state_d = rq_pkg::S_PURGE;
						end
					end else begin
						ctl.remove = 1'b1;
					end
				end else if (rdata.done != 4'd0 &&
					({1'b0, rdata.tm} + {1'b0, retry}) > {1'b0, now_q}) begin
					idx_d = idx_p1;
				end else begin
					emit = 1'b1;
					res_d = '{kind: rq_pkg::KIND_TX, status: rq_pkg::ST_OK, seq: rdata.seq,
						rcpt: rdata.rcpt, slot: rdata.slot, len: rdata.len,
						attempt: rdata.done + 1'b1, sent: 5'd0, last: 1'b0};
					wdata.tm = now_q;
					wdata.done = rdata.done + 1'b1;
					if (out_free) begin
						sent_d = sent_q + 1'b1;
						if (rdata.maxa <= 4'd1) begin
							ctl.remove = 1'b1;
						end else begin
							ctl.update = 1'b1;
							idx_d = idx_p1;
						end
					end
				end
			end
			rq_pkg::S_PURGE: begin
				rd_idx = idx_p1[IW-1:0];
				if (nxt_in && rdata.rcpt == rr_q) begin
					ctl.remove = 1'b1;
					idx = idx_p1[IW-1:0];
				end else begin
					ctl.remove = 1'b1;
					state_d = rq_pkg::S_SEND;
				end
			end
			default: state_d = rq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rq_pkg::S_IDLE;
			ctr_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ctr_q <= ctr_d;
			if (emit && out_free) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		best_q <= best_d;
		best_done_q <= best_done_d;
		used_q <= used_d;
		first_q <= first_d;
		bslot_q <= bslot_d;
		sent_q <= sent_d;
		rr_q <= rr_d;
		if (emit && out_free) begin
			res_q <= res_d;
		end
		if (state_q == rq_pkg::S_IDLE && in_valid) begin
			rcpt_q <= recipient_id;
			slot_q <= buffer_slot;
			len_q <= msg_length;
			maxa_q <= attempt_limit;
			ack_q <= ack_sequence;
			now_q <= now;
		end
	end
endmodule

// ===== src/retransmit_queue.sv =====
// Top level of the retransmit queue: configuration registers, sequencer and entry table.
// Depends on rq_pkg, rq_table, rq_seq and assert_macros.svh.
//
// channel   direction  handshake            payload
// input     in         in_valid/in_stall    action .. now
// output    out        out_valid/out_stall  kind .. last
// config    in         cfg_we               cfg_index, cfg_wdata
//
// An item is taken when idle, then walks the table one entry per cycle while no result
// word waits. Allocation scans all entries and, if every slot is taken, evicts entries;
// acknowledge scans up to the matching entry; a send pass scans all entries, purging after
// each unreachable report. Result words wait for a free output register, so out_stall
// lengthens the item. Reset empties the table at once; no input is taken meanwhile.
module retransmit_queue #(
	parameter int unsigned QUEUE_DEPTH = rq_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned SLOT_COUNT = rq_pkg::SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] recipient_id,
	input  logic [2:0]  buffer_slot,
	input  logic [9:0]  msg_length,
	input  logic [3:0]  attempt_limit,
	input  logic [31:0] ack_sequence,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [1:0]  status,
	output logic [31:0] sequence_res,
	output logic [15:0] out_recipient,
	output logic [2:0]  out_slot,
	output logic [9:0]  out_length,
	output logic [3:0]  attempt,
	output logic [4:0]  sent_count,
	output logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);
	localparam int unsigned IW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic [1:0] conn_q;
	logic [31:0] retry_q;
	logic busy;
	rq_pkg::tbl_ctl_t ctl;
	logic [IW-1:0] idx, rd_idx;
	rq_pkg::entry_t wdata, rdata;
	logic [CW-1:0] cnt;
	rq_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_q <= '0;
			retry_q <= rq_pkg::RETRY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rq_pkg::CFG_CONN:  conn_q <= cfg_wdata[1:0];
				rq_pkg::CFG_RETRY: retry_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_stall = busy;

	rq_seq #(.QUEUE_DEPTH(QUEUE_DEPTH), .SLOT_COUNT(SLOT_COUNT)) u_seq (
		.clk, .arst_n, .in_valid, .busy, .action, .recipient_id, .buffer_slot,
		.msg_length, .attempt_limit, .ack_sequence, .now,
		.conn(conn_q), .retry(retry_q),
		.ctl, .idx, .wdata, .rd_idx, .rdata, .cnt,
		.out_valid, .out_stall, .res
	);

	rq_table #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_table (
		.clk, .arst_n, .ctl, .idx, .wdata, .rd_idx, .rdata, .cnt
	);

	assign kind = res.kind;
	assign status = res.status;
	assign sequence_res = res.seq;
	assign out_recipient = res.rcpt;
	assign out_slot = res.slot;
	assign out_length = res.len;
	assign attempt = res.attempt;
	assign sent_count = res.sent;
	assign last = res.last;

`include "assert_macros.svh"
	`RQ_ASSERT(a_cnt_bound, clk, arst_n, cnt <= CW'(QUEUE_DEPTH))
	`RQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`RQ_ASSERT(a_no_remove_and_append, clk, arst_n, !(ctl.remove && ctl.append))
endmodule

// ===== verif/retransmit_queue_checker.sv =====
// Checker for the retransmit queue: watches the input, output and register write ports,
// predicts every result word from its own copy of the table, and counts mismatches.
// Depends on rq_pkg.
`timescale 1ns / 1ps

module retransmit_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] recipient_id,
	input  logic [2:0]  buffer_slot,
	input  logic [9:0]  msg_length,
	input  logic [3:0]  attempt_limit,
	input  logic [31:0] ack_sequence,
	input  logic [31:0] now,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  kind,
	input  logic [1:0]  status,
	input  logic [31:0] sequence_res,
	input  logic [15:0] out_recipient,
	input  logic [2:0]  out_slot,
	input  logic [9:0]  out_length,
	input  logic [3:0]  attempt,
	input  logic [4:0]  sent_count,
	input  logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	output int          mismatches,
	output int          pending
);
	localparam int DEPTH = rq_pkg::QUEUE_DEPTH_DEF;
	localparam int SLOTS = rq_pkg::SLOT_COUNT_DEF;

	rq_pkg::entry_t  table_q[$];
	logic [1:0]      conn_state;
	logic [31:0]     retry_gap;
	logic [31:0]     seq_counter;
	rq_pkg::result_t expected_words[$];

	assign pending = expected_words.size();

	function automatic rq_pkg::result_t make_word(logic [2:0] k, logic [1:0] st,
			logic [31:0] sq, logic [15:0] rc, logic [2:0] sl, logic [9:0] ln,
			logic [3:0] at, logic [4:0] sn, logic lt);
		rq_pkg::result_t w;
		w.kind = k; w.status = st; w.seq = sq; w.rcpt = rc; w.slot = sl;
		w.len = ln; w.attempt = at; w.sent = sn; w.last = lt;
		return w;
	endfunction

	task automatic predict_item();
		bit             used[SLOTS];
		int             best;
		int             i;
		logic [2:0]     s;
		logic [4:0]     sent;
		logic [15:0]    r;
		rq_pkg::entry_t e;
		bit             found;
		case (action)
			rq_pkg::ACT_ALLOC: begin
				best = 0;
				for (i = 0; i < SLOTS; i++) used[i] = 0;
				for (i = 0; i < table_q.size(); i++) begin
					used[table_q[i].slot] = 1;
					if (table_q[i].done > table_q[best].done) best = i;
				end
				for (i = 0; i < SLOTS; i++)
					if (!used[i]) break;
				if (i < SLOTS) begin
					expected_words.push_back(make_word(rq_pkg::KIND_GRANT, rq_pkg::ST_OK, 0, 0,
						3'(i), 0, 0, 0, 1));
				end else begin
					s = table_q[best].slot;
					table_q.delete(best);
					while (best < table_q.size() && table_q[best].slot == s) table_q.delete(best);
					expected_words.push_back(make_word(rq_pkg::KIND_GRANT, rq_pkg::ST_OK, 0, 0,
						s, 0, 0, 0, 1));
				end
			end
			rq_pkg::ACT_ENQ: begin
				if (table_q.size() >= DEPTH) begin
					expected_words.push_back(make_word(rq_pkg::KIND_ENQ, rq_pkg::ST_FULL, 0, 0,
						0, 0, 0, 0, 1));
				end else begin
					seq_counter = seq_counter + 1;
					e.seq = seq_counter; e.rcpt = recipient_id; e.slot = buffer_slot;
					e.len = msg_length; e.maxa = attempt_limit; e.done = 0; e.tm = 0;
					table_q.push_back(e);
					expected_words.push_back(make_word(rq_pkg::KIND_ENQ, rq_pkg::ST_OK,
						seq_counter, 0, 0, 0, 0, 0, 1));
				end
			end
			rq_pkg::ACT_ACK: begin
				if (conn_state != rq_pkg::CONN_CONNECTED) begin
					expected_words.push_back(make_word(rq_pkg::KIND_ACK, rq_pkg::ST_BAD_STATE,
						ack_sequence, 0, 0, 0, 0, 0, 1));
				end else begin
					found = 0;
					for (i = 0; i < table_q.size(); i++)
						if (!found && table_q[i].seq == ack_sequence) begin
							table_q.delete(i);
							found = 1;
						end
					expected_words.push_back(make_word(rq_pkg::KIND_ACK,
						found ? rq_pkg::ST_OK : rq_pkg::ST_NOT_FOUND,
						ack_sequence, 0, 0, 0, 0, 0, 1));
				end
			end
			default: begin
				if (conn_state != rq_pkg::CONN_JOINING &&
						conn_state != rq_pkg::CONN_CONNECTED) begin
					expected_words.push_back(make_word(rq_pkg::KIND_DONE, rq_pkg::ST_BAD_STATE,
						0, 0, 0, 0, 0, 0, 1));
				end else begin
					sent = 0;
					i = 0;
					while (i < table_q.size()) begin
						if (table_q[i].done >= table_q[i].maxa) begin
							if (table_q[i].maxa > 1) begin
								r = table_q[i].rcpt;
								expected_words.push_back(make_word(rq_pkg::KIND_UNREACH,
									rq_pkg::ST_OK, 0, r, 0, 0, 0, 0, 0));
								while (i + 1 < table_q.size() && table_q[i + 1].rcpt == r)
									table_q.delete(i + 1);
							end
							table_q.delete(i);
						end else if (table_q[i].done != 0 &&
								({1'b0, table_q[i].tm} + {1'b0, retry_gap}) > {1'b0, now}) begin
							i++;
						end else begin
							table_q[i].tm = now;
							table_q[i].done = table_q[i].done + 1;
							sent++;
							expected_words.push_back(make_word(rq_pkg::KIND_TX, rq_pkg::ST_OK,
								table_q[i].seq, table_q[i].rcpt, table_q[i].slot,
								table_q[i].len, table_q[i].done, 0, 0));
							if (table_q[i].maxa <= 1) table_q.delete(i);
							else i++;
						end
					end
					expected_words.push_back(make_word(rq_pkg::KIND_DONE, rq_pkg::ST_OK, 0, 0,
						0, 0, 0, sent, 1));
				end
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic compare_word();
		rq_pkg::result_t w;
		if (expected_words.size() == 0) begin
			report_mismatch("unexpected word, kind", 32'(kind), 32'd0);
			return;
		end
		w = expected_words.pop_front();
		if (kind !== w.kind) report_mismatch("kind", 32'(kind), 32'(w.kind));
		if (status !== w.status) report_mismatch("status", 32'(status), 32'(w.status));
		if (sequence_res !== w.seq) report_mismatch("sequence", sequence_res, w.seq);
		if (out_recipient !== w.rcpt)
			report_mismatch("recipient", 32'(out_recipient), 32'(w.rcpt));
		if (out_slot !== w.slot) report_mismatch("slot", 32'(out_slot), 32'(w.slot));
		if (out_length !== w.len) report_mismatch("length", 32'(out_length), 32'(w.len));
		if (attempt !== w.attempt)
			report_mismatch("attempt", 32'(attempt), 32'(w.attempt));
		if (sent_count !== w.sent)
			report_mismatch("sent count", 32'(sent_count), 32'(w.sent));
		if (last !== w.last) report_mismatch("last", 32'(last), 32'(w.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_q.delete();
			expected_words.delete();
			conn_state <= 2'd0;
			retry_gap <= rq_pkg::RETRY_RESET;
			seq_counter = 0;
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) compare_word();
			if (in_valid && !in_stall) predict_item();
			if (cfg_we) begin
				if (cfg_index == rq_pkg::CFG_CONN) conn_state <= cfg_wdata[1:0];
				else retry_gap <= cfg_wdata;
			end
		end
	end
endmodule

// ===== verif/tb_retransmit_queue.sv =====
// Testbench top for the retransmit queue: clock, reset, stimulus and verdict.
// Depends on rq_pkg, retransmit_queue and retransmit_queue_checker.
`timescale 1ns / 1ps

module tb_retransmit_queue;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  action = rq_pkg::ACT_ALLOC;
	logic [15:0] recipient_id = 0;
	logic [2:0]  buffer_slot = 0;
	logic [9:0]  msg_length = 0;
	logic [3:0]  attempt_limit = 0;
	logic [31:0] ack_sequence = 0;
	logic [31:0] now = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  kind;
	logic [1:0]  status;
	logic [31:0] sequence_res;
	logic [15:0] out_recipient;
	logic [2:0]  out_slot;
	logic [9:0]  out_length;
	logic [3:0]  attempt;
	logic [4:0]  sent_count;
	logic        last;
	logic        cfg_we = 0;
	logic        cfg_index = rq_pkg::CFG_CONN;
	logic [31:0] cfg_wdata = 0;
	int          mismatches;
	int          pending;
	int          cycles = 0;
	logic [31:0] clock_now = 0;
	logic [31:0] last_seq = 0;

	always #5 clk = ~clk;

	retransmit_queue dut (.*);

	retransmit_queue_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("retransmit_queue regression: fail");
			$finish;
		end
	end

	// The receiver stalls at random, with a density that changes from time to time.
	int stall_pct = 30;
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(0, 3) * 25;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk)
		if (out_valid && !out_stall && kind == rq_pkg::KIND_ENQ) last_seq <= sequence_res;

	// The block is busy in the cycle after it takes a word, so the extra edge costs nothing.
	task automatic send_word(logic [1:0] act, logic [15:0] rc, logic [2:0] sl,
			logic [9:0] ln, logic [3:0] mx, logic [31:0] ak, logic [31:0] tn);
		in_valid <= 1;
		action <= act; recipient_id <= rc; buffer_slot <= sl; msg_length <= ln;
		attempt_limit <= mx; ack_sequence <= ak; now <= tn;
		do @(posedge clk); while (in_stall);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		drain();
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_word();
		int pick;
		logic [31:0] ak;
		pick = $urandom_range(0, 99);
		ak = ($urandom_range(0, 3) == 0) ? $urandom() : last_seq - $urandom_range(0, 6);
		clock_now = clock_now + $urandom_range(0, 1500);
		if (pick < 40)
			send_word(rq_pkg::ACT_ENQ,
				($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3)),
				3'($urandom()), 10'($urandom()), 4'($urandom_range(0, 15)),
				$urandom(), $urandom());
		else if (pick < 55) send_word(rq_pkg::ACT_ALLOC, 16'($urandom()), 3'($urandom()),
			10'($urandom()), 4'($urandom()), $urandom(), $urandom());
		else if (pick < 75) send_word(rq_pkg::ACT_ACK, 16'($urandom()), 3'($urandom()),
			10'($urandom()), 4'($urandom()), ak, $urandom());
		else send_word(rq_pkg::ACT_SEND, 16'($urandom()), 3'($urandom()), 10'($urandom()),
			4'($urandom()), $urandom(), ($urandom_range(0, 7) == 0) ? $urandom() : clock_now);
	endtask

	initial begin
		int n;
		int burst;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed words: wrong state, full table, eviction, extremes.
		send_word(rq_pkg::ACT_SEND, 0, 0, 0, 0, 0, 0);
		send_word(rq_pkg::ACT_ACK, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
		send_word(rq_pkg::ACT_ALLOC, 0, 0, 0, 0, 0, 0);
		for (n = 0; n < 17; n++)
			send_word(rq_pkg::ACT_ENQ, n[0] ? 16'hFFFF : 16'h0, n[2:0],
				n[0] ? 10'h3FF : 10'h0, n[3:0], 0, 0);
		write_reg(rq_pkg::CFG_CONN, 32'(rq_pkg::CONN_JOINING));
		write_reg(rq_pkg::CFG_RETRY, 0);
		send_word(rq_pkg::ACT_SEND, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send_word(rq_pkg::ACT_ALLOC, 0, 0, 0, 0, 0, 0);
		write_reg(rq_pkg::CFG_CONN, 32'(rq_pkg::CONN_CONNECTED));
		send_word(rq_pkg::ACT_ACK, 0, 0, 0, 0, 32'd5, 0);
		send_word(rq_pkg::ACT_ACK, 0, 0, 0, 0, 32'd5, 0);
		send_word(rq_pkg::ACT_SEND, 0, 0, 0, 0, 0, 0);

		for (int phase = 0; phase < 4; phase++) begin
			write_reg(rq_pkg::CFG_CONN, (phase == 3) ? 32'd3 :
				((phase == 0) ? 32'(rq_pkg::CONN_CONNECTED) : 32'(phase)));
			write_reg(rq_pkg::CFG_RETRY,
				(phase == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 2000)));
			n = 0;
			while (n < 75) begin
				burst = $urandom_range(1, 8);
				repeat (burst) begin
					random_word();
					n++;
				end
				if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 30)) @(posedge clk);
			end
			drain();
		end

		drain();
		if (mismatches == 0)
			$display("retransmit_queue regression: pass");
		else
			$display("retransmit_queue regression: fail");
		$finish;
	end
endmodule
